[hdl/qtal_pkg.sv]
// Package for the Q-table action learner: shared widths, codes, FSM states,
// control structs and the divide-by-six row mean helper. No dependencies.
`default_nettype none
package qtal_pkg;

  localparam int NUM_LEVELS = 6;
  localparam int VAL_W      = 16;
  localparam int Q_ONE      = 32768;
  localparam int Q_HALF     = 16384;
  localparam int Q_SHIFT    = 15;
  localparam int REW_W      = 24;
  localparam int TD_W       = 25;
  localparam int TDK_W      = 29;
  localparam int MPROD_W    = 46;
  localparam int STEP_W     = 22;
  localparam int STEP_LIM   = 1048576;
  localparam int PROD_W     = 32;
  localparam int DOT_W      = 35;
  localparam int RSUM_W     = 19;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 16;
  localparam int ACT_W      = 3;
  localparam int IDX_W      = 4;
  localparam int PICK_W     = 3;

  localparam logic [CFG_W-1:0] LEARN_RATE_RST   = 16'd3277;
  localparam logic [CFG_W-1:0] DISCOUNT_RST     = 16'd29491;
  localparam logic [CFG_W-1:0] EXPLORE_RATE_RST = 16'd9830;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARN_RATE   = 2'd0,
    REG_DISCOUNT     = 2'd1,
    REG_EXPLORE_RATE = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TGT,
    ST_TD,
    ST_MUL,
    ST_RND,
    ST_WR,
    ST_MEAN_B,
    ST_MEAN_C,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic scan;
    logic td_ld;
    logic mul;
    logic rnd;
    logic wr;
  } lane_ctl_t;

  typedef struct packed {
    logic clr;
    logic b_en;
    logic c_en;
  } merge_ctl_t;

  // Rounded mean of six entries: (sum + 3) / 6 by reciprocal and one correction.
  function automatic logic [VAL_W-1:0] div6_round(input logic [RSUM_W-1:0] sum);
    logic [RSUM_W-1:0] x;
    logic [38:0]       p;
    logic [RSUM_W-1:0] q;
    logic [RSUM_W-1:0] r;
    x = sum + 19'd3;
    p = 39'(x) * 39'd174762;
    q = p[38:20];
    r = x - 19'(q * 19'd6);
    if (r >= 19'd6) q = q + 19'd1;
    return q[VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hdl/qtal_if.sv]
// Valid/ready channel interfaces for the request and result words.
// Depends on nothing; widths follow the fixed field widths of the block.
`default_nettype none
interface qtal_req_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [3:0]         action_index;
  logic signed [23:0] reward;
  logic [15:0]        level_0;
  logic [15:0]        level_1;
  logic [15:0]        level_2;
  logic [15:0]        level_3;
  logic [15:0]        level_4;
  logic [15:0]        level_5;
  logic [15:0]        random_draw;
  logic [2:0]         random_pick;
  modport source(output valid, action, action_index, reward, level_0, level_1, level_2,
                 level_3, level_4, level_5, random_draw, random_pick, input ready);
  modport sink(input valid, action, action_index, reward, level_0, level_1, level_2,
               level_3, level_4, level_5, random_draw, random_pick, output ready);
endinterface

interface qtal_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  chosen_action;
  logic        was_exploration;
  logic [15:0] row_weight;
  logic        index_rejected;
  modport source(output valid, chosen_action, was_exploration, row_weight, index_rejected,
                 input ready);
  modport sink(input valid, chosen_action, was_exploration, row_weight, index_rejected,
               output ready);
endinterface
`default_nettype wire

[hdl/qtal_lane.sv]
// One column lane of the value table: holds the column, forms dot-product terms
// and applies the TD step to one entry. Depends on qtal_pkg.
`default_nettype none
module qtal_lane #(
  parameter int NUM_ACTIONS = 7,
  parameter int LANE        = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  qtal_pkg::lane_ctl_t                    ctl,
  input  logic [$clog2(NUM_ACTIONS)-1:0]         row,
  input  logic [qtal_pkg::VAL_W-1:0]             level,
  input  logic [qtal_pkg::CFG_W-1:0]             lr,
  input  logic signed [qtal_pkg::TD_W-1:0]       td,
  output logic [qtal_pkg::VAL_W-1:0]             ent,
  output logic [qtal_pkg::PROD_W-1:0]            prod
);
  import qtal_pkg::*;

  localparam int K_NUM = (LANE == 0) ? 6 : ((LANE == 2) ? 11 : 1);
  localparam int K_DEN = (LANE == 0) ? 5 : ((LANE == 2) ? 10 : 1);
  localparam int DSH   = (K_DEN == 10) ? 1 : 0;
  localparam logic signed [MPROD_W-1:0] RND_HALF = MPROD_W'(K_DEN * Q_HALF);
  localparam logic signed [MPROD_W-1:0] LIM_HI   = MPROD_W'(STEP_LIM);
  localparam logic signed [MPROD_W-1:0] LIM_LO   = -MPROD_W'(STEP_LIM);

  logic [VAL_W-1:0]          val [NUM_ACTIONS];
  logic signed [TDK_W-1:0]   tdk;
  logic signed [MPROD_W-1:0] mprod;
  logic signed [STEP_W-1:0]  ystep;
  logic signed [MPROD_W-1:0] yfull;
  logic signed [STEP_W-1:0]  ysat;
  logic signed [STEP_W-1:0]  step;
  logic signed [STEP_W-1:0]  vsum;
  logic [VAL_W-1:0]          vnew;

  // Floor division of a signed value by five.
  function automatic logic signed [STEP_W-1:0] fdiv5(input logic signed [STEP_W-1:0] y);
    logic              neg;
    logic [STEP_W-1:0] m;
    logic [39:0]       p;
    logic [STEP_W-1:0] q;
    logic [STEP_W-1:0] r;
    neg = y[STEP_W-1];
    m = neg ? (STEP_W'(-y) + 22'd4) : STEP_W'(y);
    p = 40'(m) * 40'd209715;
    q = STEP_W'(p[39:20]);
    r = m - STEP_W'(q * 22'd5);
    if (r >= 22'd5) q = q + 22'd1;
    return neg ? -$signed(q) : $signed(q);
  endfunction

  always_comb begin
    yfull = (mprod + RND_HALF) >>> (Q_SHIFT + DSH);
    if (yfull > LIM_HI) begin
      ysat = STEP_W'(STEP_LIM);
    end else if (yfull < LIM_LO) begin
      ysat = -STEP_W'(STEP_LIM);
    end else begin
      ysat = STEP_W'(yfull);
    end
    step = (K_DEN == 1) ? ystep : fdiv5(ystep);
    vsum = $signed({6'b0, val[row]}) + step;
    if (vsum < 0) begin
      vnew = '0;
    end else if (vsum > STEP_W'(Q_ONE)) begin
      vnew = VAL_W'(Q_ONE);
    end else begin
      vnew = vsum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ACTIONS; i++) val[i] <= VAL_W'(Q_HALF);
    end else if (ctl.wr) begin
      val[row] <= vnew;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      ent  <= val[row];
      prod <= PROD_W'(val[row]) * PROD_W'(level);
    end else if (ctl.wr) begin
      ent <= vnew;
    end
    if (ctl.td_ld) tdk <= TDK_W'(td) * $signed(TDK_W'(K_NUM));
    if (ctl.mul) mprod <= $signed({1'b0, lr}) * tdk;
    if (ctl.rnd) ystep <= ysat;
  end

endmodule
`default_nettype wire

[hdl/qtal_merge.sv]
// Merge stage: sums the six lane terms per row, then tracks the best dot
// product, best row mean, the chosen row's mean and the last mean. Uses qtal_pkg.
`default_nettype none
module qtal_merge #(
  parameter int NUM_ACTIONS = 7
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  qtal_pkg::merge_ctl_t                                    ctl,
  input  logic [$clog2(NUM_ACTIONS)-1:0]                          row,
  input  logic [$clog2(NUM_ACTIONS)-1:0]                          sel_row,
  input  logic [qtal_pkg::NUM_LEVELS-1:0][qtal_pkg::VAL_W-1:0]    ent,
  input  logic [qtal_pkg::NUM_LEVELS-1:0][qtal_pkg::PROD_W-1:0]   prod,
  output logic [$clog2(NUM_ACTIONS)-1:0]                          best_act,
  output logic [qtal_pkg::VAL_W-1:0]                              best_mean,
  output logic [qtal_pkg::VAL_W-1:0]                              row_mean,
  output logic [qtal_pkg::VAL_W-1:0]                              last_mean
);
  import qtal_pkg::*;

  localparam int ROW_W = $clog2(NUM_ACTIONS);

  logic [DOT_W-1:0]  dot_sum;
  logic [RSUM_W-1:0] rsum_sum;
  logic [DOT_W-1:0]  dot;
  logic [RSUM_W-1:0] rsum;
  logic [ROW_W-1:0]  b_row;
  logic [VAL_W-1:0]  mean_b;
  logic [DOT_W-1:0]  best_dot;

  always_comb begin
    dot_sum  = '0;
    rsum_sum = '0;
    for (int s = 0; s < NUM_LEVELS; s++) begin
      dot_sum  = dot_sum + DOT_W'(prod[s]);
      rsum_sum = rsum_sum + RSUM_W'(ent[s]);
    end
    mean_b = div6_round(rsum);
  end

  always_ff @(posedge clk) begin
    if (ctl.b_en) begin
      dot   <= dot_sum;
      rsum  <= rsum_sum;
      b_row <= row;
    end
  end

  // Strict compares keep the lowest row on ties.
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      best_dot  <= '0;
      best_act  <= '0;
      best_mean <= '0;
    end else if (ctl.c_en) begin
      if (dot > best_dot) begin
        best_dot <= dot;
        best_act <= b_row;
      end
      if (mean_b > best_mean) best_mean <= mean_b;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.c_en) begin
      if (b_row == sel_row) row_mean <= mean_b;
      last_mean <= mean_b;
    end
  end

endmodule
`default_nettype wire

[hdl/q_table_action_learner.sv]
// Q-table action learner: six column lanes and a merge stage, one word at a time.
// The result can first be taken in the cycle in which the next word can be accepted.
// Exploiting select: row sweep through the lanes, two merge stages. Update: sweep,
// target, three lane step stages, write, mean. Exploring select and rejected update
// go straight to the result. A waiting result delays the next result.
// Synchronous reset sets every table entry to 0.5 at once and loads the register defaults.
`default_nettype none
module q_table_action_learner #(
  parameter int NUM_ACTIONS = 7
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [qtal_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qtal_pkg::CFG_W-1:0]      cfg_data,
  qtal_req_if.sink                        req,
  qtal_rsp_if.source                      rsp
);
  import qtal_pkg::*;

  localparam int ROW_W = $clog2(NUM_ACTIONS);
  localparam int CNT_W = $clog2(NUM_ACTIONS + 2);

  // Configuration registers; the user must write them only while the block is idle (not enforced).
  logic [CFG_W-1:0] learn_rate;
  logic [CFG_W-1:0] discount;
  logic [CFG_W-1:0] explore_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate   <= LEARN_RATE_RST;
      discount     <= DISCOUNT_RST;
      explore_rate <= EXPLORE_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARN_RATE:   learn_rate   <= cfg_data;
        REG_DISCOUNT:     discount     <= cfg_data;
        REG_EXPLORE_RATE: explore_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state and the captured request word.
  state_t                      state, state_next;
  logic [CNT_W-1:0]            cnt, cnt_next;
  logic                        op_upd;
  logic                        explore;
  logic                        rejected;
  logic [ROW_W-1:0]            sel_row;
  logic signed [REW_W-1:0]     reward;
  logic [NUM_LEVELS-1:0][VAL_W-1:0] lvl;
  logic [PICK_W-1:0]           pick;
  logic [PROD_W-1:0]           dprod;

  logic                        accept;
  logic                        emit_load;
  lane_ctl_t                   lane_ctl;
  merge_ctl_t                  mrg_ctl;
  logic [ROW_W-1:0]            lane_row;
  logic [ROW_W-1:0]            mrg_row;
  logic [CNT_W-1:0]            cnt_m1;

  logic [NUM_LEVELS-1:0][VAL_W-1:0]  ent;
  logic [NUM_LEVELS-1:0][PROD_W-1:0] prod;
  logic [ROW_W-1:0]            best_act;
  logic [VAL_W-1:0]            best_mean;
  logic [VAL_W-1:0]            row_mean;
  logic [VAL_W-1:0]            last_mean;

  logic [16:0]                 term;
  logic signed [25:0]          tgt_wide;
  logic signed [REW_W-1:0]     target;
  logic signed [TD_W-1:0]      td;
  logic [4:0]                  pick_mod;

  logic                        out_valid;
  logic [ACT_W-1:0]            out_action;
  logic                        out_explore;
  logic [VAL_W-1:0]            out_weight;
  logic                        out_rejected;

  assign accept    = req.valid && req.ready;
  assign req.ready = !rst && (state == ST_IDLE);
  assign cnt_m1    = cnt - CNT_W'(1);

  // A random pick beyond the table wraps by repeated subtraction.
  always_comb begin
    pick_mod = 5'(pick);
    for (int i = 0; i < 4; i++) begin
      if (pick_mod >= 5'(NUM_ACTIONS)) pick_mod = pick_mod - 5'(NUM_ACTIONS);
    end
  end

  // TD target: reward plus rounded discount times best mean, saturated to
  // 24 bits; the error against the chosen row's mean fits in 25 bits.
  always_comb begin
    term     = 17'((dprod + 32'd16384) >> Q_SHIFT);
    tgt_wide = $signed({{2{reward[REW_W-1]}}, reward}) + $signed({9'b0, term});
    if (tgt_wide > 26'sd8388607) begin
      target = 24'sd8388607;
    end else if (tgt_wide < -26'sd8388608) begin
      target = -24'sd8388608;
    end else begin
      target = tgt_wide[REW_W-1:0];
    end
    td = TD_W'(target) - $signed({9'b0, row_mean});
  end

  // Next state and the per-cycle strobes to lanes and merge. During the row
  // sweep the lanes read row cnt, the merge sums row cnt-1 and compares row cnt-2.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    lane_ctl   = '0;
    mrg_ctl    = '0;
    lane_row   = sel_row;
    mrg_row    = sel_row;
    emit_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          mrg_ctl.clr = 1'b1;
          cnt_next    = '0;
          if (!req.action && (req.random_draw < explore_rate)) begin
            state_next = ST_EMIT;
          end else if (req.action &&
                       ({1'b0, req.action_index} >= (IDX_W+1)'(NUM_ACTIONS))) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        lane_row      = cnt[ROW_W-1:0];
        mrg_row       = cnt_m1[ROW_W-1:0];
        lane_ctl.scan = (cnt < CNT_W'(NUM_ACTIONS));
        mrg_ctl.b_en  = (cnt >= CNT_W'(1)) && (cnt <= CNT_W'(NUM_ACTIONS));
        mrg_ctl.c_en  = (cnt >= CNT_W'(2));
        cnt_next      = cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_ACTIONS + 1)) begin
          state_next = op_upd ? ST_TGT : ST_EMIT;
        end
      end
      ST_TGT: begin
        state_next = ST_TD;
      end
      ST_TD: begin
        lane_ctl.td_ld = 1'b1;
        state_next     = ST_MUL;
      end
      ST_MUL: begin
        lane_ctl.mul = 1'b1;
        state_next   = ST_RND;
      end
      ST_RND: begin
        lane_ctl.rnd = 1'b1;
        state_next   = ST_WR;
      end
      ST_WR: begin
        lane_ctl.wr = 1'b1;
        state_next  = ST_MEAN_B;
      end
      ST_MEAN_B: begin
        mrg_ctl.b_en = 1'b1;
        state_next   = ST_MEAN_C;
      end
      ST_MEAN_C: begin
        mrg_ctl.c_en = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        // The result register takes the word once the previous one is gone.
        if (!out_valid || rsp.ready) begin
          emit_load  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Request capture and the discount product, held for the whole item.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_upd   <= req.action;
      explore  <= !req.action && (req.random_draw < explore_rate);
      rejected <= req.action && ({1'b0, req.action_index} >= (IDX_W+1)'(NUM_ACTIONS));
      sel_row  <= req.action_index[ROW_W-1:0];
      reward   <= req.reward;
      lvl[0]   <= req.level_0;
      lvl[1]   <= req.level_1;
      lvl[2]   <= req.level_2;
      lvl[3]   <= req.level_3;
      lvl[4]   <= req.level_4;
      lvl[5]   <= req.level_5;
      pick     <= req.random_pick;
    end
    if (state == ST_TGT) dprod <= PROD_W'(discount) * PROD_W'(best_mean);
  end

  // One lane per table column.
  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_lane
    qtal_lane #(
      .NUM_ACTIONS(NUM_ACTIONS),
      .LANE(g)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctl  (lane_ctl),
      .row  (lane_row),
      .level(lvl[g]),
      .lr   (learn_rate),
      .td   (td),
      .ent  (ent[g]),
      .prod (prod[g])
    );
  end

  qtal_merge #(
    .NUM_ACTIONS(NUM_ACTIONS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mrg_ctl),
    .row      (mrg_row),
    .sel_row  (sel_row),
    .ent      (ent),
    .prod     (prod),
    .best_act (best_act),
    .best_mean(best_mean),
    .row_mean (row_mean),
    .last_mean(last_mean)
  );

  // Result register: decouples the finished word from the sink's ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_action   <= op_upd ? '0 : (explore ? ACT_W'(pick_mod) : ACT_W'(best_act));
      out_explore  <= !op_upd && explore;
      out_weight   <= (op_upd && !rejected) ? last_mean : '0;
      out_rejected <= op_upd && rejected;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.chosen_action   = out_action;
  assign rsp.was_exploration = out_explore;
  assign rsp.row_weight      = out_weight;
  assign rsp.index_rejected  = out_rejected;

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the Q-table action learner: drives select and update
// words, predicts each result with an in-bench model of the value table and checks it.
// Depends on hdl/qtal_pkg.sv, hdl/qtal_if.sv and hdl/q_table_action_learner.sv.
`timescale 1ns / 1ps
module testbench;
  import qtal_pkg::*;

  localparam int ACTIONS = 7;
  localparam int MAX_CYCLES = 400000;

  typedef struct packed {
    logic [2:0]  chosen_action;
    logic        was_exploration;
    logic [15:0] row_weight;
    logic        index_rejected;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  qtal_req_if req ();
  qtal_rsp_if rsp ();

  q_table_action_learner #(.NUM_ACTIONS(ACTIONS)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // The bench keeps its own copy of the table and registers.
  logic [15:0] q_values [ACTIONS*6];
  logic [15:0] rate_lr, rate_disc, rate_explore;
  outcome_t pending_outcomes [$];
  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Seed the request channel with defined values from time zero.
  initial begin
    req.valid = 1'b0; req.action = 1'b0; req.action_index = '0; req.reward = '0;
    req.level_0 = '0; req.level_1 = '0; req.level_2 = '0; req.level_3 = '0;
    req.level_4 = '0; req.level_5 = '0; req.random_draw = '0; req.random_pick = '0;
    rsp.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [15:0] mean_of_row(int row);
    int total;
    total = 0;
    for (int s = 0; s < 6; s++) total += q_values[row*6+s];
    return 16'((total + 3) / 6);
  endfunction

  // Computes the expected answer for one request word and advances the table.
  function automatic outcome_t learner_predict(logic op, logic [3:0] idx,
                                               logic signed [23:0] rew,
                                               logic [15:0] lv [6],
                                               logic [15:0] draw, logic [2:0] pick);
    outcome_t o;
    longint best_val, acc, target, td, stp, v, best_mean, m;
    int best;
    longint num, den;
    o = '0;
    if (op == 1'b0) begin
      if (draw < rate_explore) begin
        o.chosen_action = 3'(pick % ACTIONS);
        o.was_exploration = 1'b1;
      end else begin
        best = 0;
        best_val = 0;
        for (int a = 0; a < ACTIONS; a++) begin
          acc = 0;
          for (int s = 0; s < 6; s++) acc += longint'(q_values[a*6+s]) * longint'(lv[s]);
          if (acc > best_val) begin
            best_val = acc;
            best = a;
          end
        end
        o.chosen_action = 3'(best);
      end
      return o;
    end
    if (idx >= ACTIONS) begin
      o.index_rejected = 1'b1;
      return o;
    end
    best_mean = 0;
    for (int a = 0; a < ACTIONS; a++) begin
      m = mean_of_row(a);
      if (m > best_mean) best_mean = m;
    end
    target = longint'(rew) + floor_div(longint'(rate_disc) * best_mean + 16384, 32768);
    if (target > 8388607) target = 8388607;
    if (target < -8388608) target = -8388608;
    td = target - longint'(mean_of_row(idx));
    for (int s = 0; s < 6; s++) begin
      num = 1; den = 1;
      if (s == 0) begin
        num = 6; den = 5;
      end else if (s == 2) begin
        num = 11; den = 10;
      end
      stp = floor_div(longint'(rate_lr) * num * td + den * 16384, den * 32768);
      v = longint'(q_values[idx*6+s]) + stp;
      if (v < 0) v = 0;
      if (v > 32768) v = 32768;
      q_values[idx*6+s] = 16'(v);
    end
    o.row_weight = mean_of_row(idx);
    return o;
  endfunction

  // Result checker: the receiver stalls at random and compares each word.
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.chosen_action, rsp.was_exploration, rsp.row_weight, rsp.index_rejected};
      if (pending_outcomes.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        if (got.chosen_action !== want.chosen_action) begin
          $error("chosen_action exp %0d got %0d", want.chosen_action, got.chosen_action);
          errors++;
        end
        if (got.was_exploration !== want.was_exploration) begin
          $error("was_exploration exp %0d got %0d", want.was_exploration,
                 got.was_exploration);
          errors++;
        end
        if (got.row_weight !== want.row_weight) begin
          $error("row_weight exp %0d got %0d", want.row_weight, got.row_weight);
          errors++;
        end
        if (got.index_rejected !== want.index_rejected) begin
          $error("index_rejected exp %0d got %0d", want.index_rejected, got.index_rejected);
          errors++;
        end
      end
    end
  end

  // Sends one request word, computing its expectation at the accepting edge.
  // It first waits for a falling edge so that the previous valid drop stands alone.
  task automatic send_word(logic op, logic [3:0] idx, logic signed [23:0] rew,
                           logic [15:0] lv [6], logic [15:0] draw, logic [2:0] pick);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    req.valid <= 1'b1; req.action <= op; req.action_index <= idx; req.reward <= rew;
    req.level_0 <= lv[0]; req.level_1 <= lv[1]; req.level_2 <= lv[2];
    req.level_3 <= lv[3]; req.level_4 <= lv[4]; req.level_5 <= lv[5];
    req.random_draw <= draw; req.random_pick <= pick;
    do @(posedge clk); while (!req.ready);
    pending_outcomes = {pending_outcomes, learner_predict(op, idx, rew, lv, draw, pick)};
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= r; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_LEARN_RATE: rate_lr = val;
      REG_DISCOUNT: rate_disc = val;
      default: rate_explore = val;
    endcase
  endtask

  // A random item: mostly levels within Q15 range, occasionally the full 16 bits.
  task automatic random_word();
    logic [15:0] lv [6];
    logic signed [23:0] rew;
    for (int s = 0; s < 6; s++)
      lv[s] = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
    case ($urandom_range(3))
      0: rew = 24'($urandom);
      1: rew = 24'(int'($urandom_range(65536)) - 32768);
      default: rew = 24'(int'($urandom_range(8192)) - 4096);
    endcase
    send_word(1'($urandom_range(1)),
              ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(ACTIONS-1)),
              rew, lv, ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768)),
              3'($urandom));
  endtask

  // Directed words: extremes of rewards, levels, indexes, picks and ties.
  task automatic test_directed();
    logic [15:0] zero_lv [6];
    logic [15:0] full_lv [6];
    logic [15:0] one_lv [6];
    zero_lv = '{default: 16'd0};
    full_lv = '{default: 16'hFFFF};
    one_lv = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd32768};
    send_word(1'b0, 4'd0, 24'sd0, zero_lv, 16'd32768, 3'd0);  // no positive dot: action 0
    send_word(1'b0, 4'd0, 24'sd0, full_lv, 16'hFFFF, 3'd0);   // tie over all rows
    send_word(1'b0, 4'd0, 24'sd0, zero_lv, 16'd0, 3'd7);      // pick wraps
    send_word(1'b0, 4'd0, 24'sd0, zero_lv, 16'd0, 3'd6);
    send_word(1'b1, 4'd3, 24'sh7FFFFF, zero_lv, 16'd0, 3'd0); // saturating target
    send_word(1'b1, 4'd5, -24'sd8388608, zero_lv, 16'd0, 3'd0);
    send_word(1'b1, 4'd6, 24'sd16384, zero_lv, 16'd0, 3'd0);
    send_word(1'b1, 4'd7, 24'sd100, zero_lv, 16'd0, 3'd0);   // rejected
    send_word(1'b1, 4'd15, -24'sd1, zero_lv, 16'd0, 3'd0);
    send_word(1'b0, 4'hF, 24'sd0, one_lv, 16'd9830, 3'd5);
    send_word(1'b0, 4'd0, 24'sd0, full_lv, 16'd32768, 3'd1);
    drain();
  endtask

  task automatic test_random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) random_word();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
  endtask

  task automatic test_config_sweep();
    write_reg(REG_LEARN_RATE, 16'd32768);
    write_reg(REG_DISCOUNT, 16'd0);
    write_reg(REG_EXPLORE_RATE, 16'd0);
    test_random_phase(60, 0, 0);
    write_reg(REG_LEARN_RATE, 16'hFFFF);
    write_reg(REG_DISCOUNT, 16'hFFFF);
    write_reg(REG_EXPLORE_RATE, 16'hFFFF);
    test_random_phase(40, 10, 10);
    write_reg(REG_LEARN_RATE, 16'd0);
    write_reg(REG_DISCOUNT, 16'd32768);
    write_reg(REG_EXPLORE_RATE, 16'd32768);
    test_random_phase(30, 0, 0);
    write_reg(REG_LEARN_RATE, 16'd3277);
    write_reg(REG_DISCOUNT, 16'd29491);
    write_reg(REG_EXPLORE_RATE, 16'd9830);
  endtask

  initial begin
    for (int i = 0; i < ACTIONS*6; i++) q_values[i] = 16'd16384;
    rate_lr = LEARN_RATE_RST;
    rate_disc = DISCOUNT_RST;
    rate_explore = EXPLORE_RATE_RST;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_phase(80, 0, 0);
    test_random_phase(50, 86, 0);
    test_random_phase(50, 0, 86);
    test_config_sweep();
    test_random_phase(60, 10, 10);
    // The pause until all expected words have arrived happens inside drain().
    test_random_phase(30, 0, 0);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

[sim.f]
hdl/qtal_pkg.sv
hdl/qtal_if.sv
hdl/qtal_lane.sv
hdl/qtal_merge.sv
hdl/q_table_action_learner.sv
sim/testbench.sv
